/* rtl/core/fbpa_pkg.sv */
// Shared types and constants of the fixed block pool allocator.
package fbpa_pkg;

    localparam int IDX_W             = 6;
    localparam int CNT_W             = 7;
    localparam int TOT_W             = 32;
    localparam int STAT_W            = 2;
    localparam int BLOCK_COUNT_RESET = 64;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_BAD_FREE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_FREE,
        OP_BAD
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] idx;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } qhead_t;

    typedef enum logic {
        B_IDLE,
        B_GRANT
    } bstate_t;

endpackage

/* rtl/core/fbpa_if.sv */
// Request and response channel interfaces of the fixed block pool allocator.
interface fbpa_req_if;
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic [fbpa_pkg::IDX_W-1:0]   block_index;

    modport source (output valid, output func, output block_index, input ready);
    modport sink   (input valid, input func, input block_index, output ready);
endinterface

interface fbpa_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [fbpa_pkg::IDX_W-1:0]   granted_index;
    logic [fbpa_pkg::STAT_W-1:0]  status;
    logic [fbpa_pkg::CNT_W-1:0]   free_blocks;
    logic [fbpa_pkg::CNT_W-1:0]   in_use;
    logic [fbpa_pkg::CNT_W-1:0]   peak_in_use;
    logic [fbpa_pkg::TOT_W-1:0]   alloc_total;
    logic [fbpa_pkg::TOT_W-1:0]   free_total;

    modport source (output valid, output granted_index, output status, output free_blocks,
                    output in_use, output peak_in_use, output alloc_total,
                    output free_total, input ready);
    modport sink   (input valid, input granted_index, input status, input free_blocks,
                    input in_use, input peak_in_use, input alloc_total,
                    input free_total, output ready);
endinterface

/* rtl/core/fixed_block_pool_allocator.sv */
// Fixed block pool allocator: hands out and takes back block indices of a pool of equal-sized
// blocks through a FIFO free list. Each request transaction on req (func 0 allocate, 1 free
// block_index) gives exactly one response transaction on rsp carrying the granted index, a
// status (ok, pool empty, bad or double free) and the pool statistics after the request.
// Frees and rejected requests pass through the back end in its idle state; a successful allocate
// also passes through the grant state, which waits for the registered read of the free-list RAM.
// Requests reach the back end through a two-entry command queue. Writing cfg_wdata with cfg_we
// re-initialises the pool (indices in ascending order, counters cleared) in the cycle after the
// write; write only while no transaction is in flight. No clearing pass is needed after reset
// or re-initialisation.
module fixed_block_pool_allocator #(
    parameter int POOL_DEPTH = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [fbpa_pkg::CNT_W-1:0] cfg_wdata,
    fbpa_req_if.sink                   req,
    fbpa_rsp_if.source                 rsp
);

    localparam int CNT_W = fbpa_pkg::CNT_W;

    logic [CNT_W-1:0]  block_count_reg;
    logic              reinit_reg;
    logic [CNT_W-1:0]  pool_size;
    fbpa_pkg::qhead_t  q_head;
    logic              q_pop;

    // Pool size register; a write re-initialises the back end on the following edge,
    // when the new size is already visible.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_count_reg <= CNT_W'(fbpa_pkg::BLOCK_COUNT_RESET);
            reinit_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                block_count_reg <= cfg_wdata;
            end
            reinit_reg <= cfg_we;
        end
    end

    // Sizes beyond the storage are clamped to it.
    assign pool_size = (32'(block_count_reg) > 32'(POOL_DEPTH)) ?
                       CNT_W'(POOL_DEPTH) : block_count_reg;

    // Front end: range-checks frees and buffers commands.
    fbpa_front u_fbpa_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pool_size (pool_size),
        .req       (req),
        .pop       (q_pop),
        .head      (q_head)
    );

    // Back end: free list, marks, counters and response register.
    fbpa_back #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_fbpa_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .reinit    (reinit_reg),
        .pool_size (pool_size),
        .head      (q_head),
        .pop       (q_pop),
        .rsp       (rsp)
    );

endmodule

/* rtl/core/fbpa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module fbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/fbpa_front.sv */
// Front end: accepts requests, classifies them and queues them for the back end.
module fbpa_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [fbpa_pkg::CNT_W-1:0] pool_size,
    fbpa_req_if.sink                   req,
    input  logic                       pop,
    output fbpa_pkg::qhead_t           head
);

    localparam int QD = fbpa_pkg::QUEUE_DEPTH;
    localparam int PW = (QD > 1) ? $clog2(QD) : 1;
    localparam int CW = $clog2(QD + 1);

    fbpa_pkg::cmd_t  slots [QD];
    fbpa_pkg::cmd_t  cmd_in;
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            push;

    // range check only; the allocated check needs back-end state
    always_comb
    begin
        cmd_in.idx = req.block_index;
        if (req.func == fbpa_pkg::FUNC_ALLOC)
        begin
            cmd_in.op = fbpa_pkg::OP_ALLOC;
        end
        else if (32'(req.block_index) < 32'(pool_size))
        begin
            cmd_in.op = fbpa_pkg::OP_FREE;
        end
        else
        begin
            cmd_in.op = fbpa_pkg::OP_BAD;
        end
    end

    assign req.ready = (count_reg != CW'(QD));
    assign push      = req.valid && req.ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QD - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QD - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= cmd_in;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.cmd   = slots[rd_ptr_reg];

endmodule

/* rtl/core/fbpa_back.sv */
// Back end: free-list FIFO, allocation marks, statistics and response register.
module fbpa_back #(
    parameter int POOL_DEPTH = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       reinit,
    input  logic [fbpa_pkg::CNT_W-1:0] pool_size,
    input  fbpa_pkg::qhead_t           head,
    output logic                       pop,
    fbpa_rsp_if.source                 rsp
);

    localparam int IDX_W    = fbpa_pkg::IDX_W;
    localparam int CNT_W    = fbpa_pkg::CNT_W;
    localparam int TOT_W    = fbpa_pkg::TOT_W;
    localparam int AW       = $clog2(POOL_DEPTH);
    localparam int GW       = (AW > IDX_W) ? AW : IDX_W;
    localparam int MN       = (POOL_DEPTH < (1 << IDX_W)) ? POOL_DEPTH : (1 << IDX_W);
    localparam int MW       = $clog2(MN);
    localparam int RST_POOL = (fbpa_pkg::BLOCK_COUNT_RESET > POOL_DEPTH) ?
                              POOL_DEPTH : fbpa_pkg::BLOCK_COUNT_RESET;
    localparam int RST_TAIL = (RST_POOL >= POOL_DEPTH) ? 0 : RST_POOL;

    fbpa_pkg::bstate_t   state_reg, state_next;
    logic [AW-1:0]       head_reg, head_next;
    logic [AW-1:0]       tail_reg, tail_next;
    logic                wrapped_reg, wrapped_next;
    logic [CNT_W-1:0]    level_reg, level_next;
    logic [CNT_W-1:0]    used_reg, used_next;
    logic [CNT_W-1:0]    peak_reg, peak_next;
    logic [TOT_W-1:0]    alloc_cnt_reg, alloc_cnt_next;
    logic [TOT_W-1:0]    free_cnt_reg, free_cnt_next;
    logic [MN-1:0]       marks_reg, marks_next;
    logic                out_valid_reg, out_valid_next;

    fbpa_pkg::status_t   out_status_reg;
    logic [IDX_W-1:0]    out_grant_reg;
    logic [CNT_W-1:0]    out_free_reg, out_used_reg, out_peak_reg;
    logic [TOT_W-1:0]    out_alloc_reg, out_freed_reg;

    fbpa_pkg::status_t   st_new;
    logic [IDX_W-1:0]    grant_new;
    logic                load;
    logic                slot_free;
    logic                ram_we;
    logic [IDX_W-1:0]    ram_rdata;
    logic                fresh;
    logic [GW-1:0]       granted_full;
    logic [CNT_W-1:0]    used_inc;
    logic [CNT_W-1:0]    used_dec;
    logic [AW-1:0]       tail_init;

    fbpa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (POOL_DEPTH)
    ) u_fbpa_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (head.cmd.idx),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    // Until the head pointer first wraps, a slot below the pool size still
    // holds its initial index and has never been written.
    assign fresh        = !wrapped_reg && (32'(head_reg) < 32'(pool_size));
    assign granted_full = fresh ? GW'(head_reg) : GW'(ram_rdata);
    assign slot_free    = !out_valid_reg || rsp.ready;
    assign used_inc     = used_reg + 1'b1;
    assign used_dec     = (used_reg != '0) ? used_reg - 1'b1 : used_reg;
    assign tail_init    = (32'(pool_size) >= 32'(POOL_DEPTH)) ? '0 : AW'(pool_size);

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        wrapped_next   = wrapped_reg;
        level_next     = level_reg;
        used_next      = used_reg;
        peak_next      = peak_reg;
        alloc_cnt_next = alloc_cnt_reg;
        free_cnt_next  = free_cnt_reg;
        marks_next     = marks_reg;
        pop            = 1'b0;
        ram_we         = 1'b0;
        load           = 1'b0;
        st_new         = fbpa_pkg::ST_OK;
        grant_new      = '0;

        if (reinit)
        begin
            state_next     = fbpa_pkg::B_IDLE;
            head_next      = '0;
            tail_next      = tail_init;
            wrapped_next   = 1'b0;
            level_next     = pool_size;
            used_next      = '0;
            peak_next      = '0;
            alloc_cnt_next = '0;
            free_cnt_next  = '0;
            marks_next     = '0;
        end
        else
        begin
            case (state_reg)
                fbpa_pkg::B_IDLE:
                begin
                    if (head.valid && slot_free)
                    begin
                        pop = 1'b1;
                        case (head.cmd.op)
                            fbpa_pkg::OP_ALLOC:
                            begin
                                if (level_reg == '0)
                                begin
                                    load   = 1'b1;
                                    st_new = fbpa_pkg::ST_EMPTY;
                                end
                                else
                                begin
                                    // RAM read of the head slot lands next cycle
                                    state_next = fbpa_pkg::B_GRANT;
                                end
                            end
                            fbpa_pkg::OP_FREE:
                            begin
                                load = 1'b1;
                                if (marks_reg[head.cmd.idx[MW-1:0]])
                                begin
                                    marks_next[head.cmd.idx[MW-1:0]] = 1'b0;
                                    ram_we        = 1'b1;
                                    tail_next     = (tail_reg == AW'(POOL_DEPTH - 1)) ?
                                                    '0 : tail_reg + 1'b1;
                                    level_next    = level_reg + 1'b1;
                                    used_next     = used_dec;
                                    free_cnt_next = free_cnt_reg + 1'b1;
                                end
                                else
                                begin
                                    st_new = fbpa_pkg::ST_BAD_FREE;
                                end
                            end
                            default:
                            begin
                                load   = 1'b1;
                                st_new = fbpa_pkg::ST_BAD_FREE;
                            end
                        endcase
                    end
                end
                fbpa_pkg::B_GRANT:
                begin
                    load       = 1'b1;
                    grant_new  = granted_full[IDX_W-1:0];
                    state_next = fbpa_pkg::B_IDLE;
                    if (32'(granted_full) < 32'(MN))
                    begin
                        marks_next[granted_full[MW-1:0]] = 1'b1;
                    end
                    if (head_reg == AW'(POOL_DEPTH - 1))
                    begin
                        head_next    = '0;
                        wrapped_next = 1'b1;
                    end
                    else
                    begin
                        head_next = head_reg + 1'b1;
                    end
                    level_next     = level_reg - 1'b1;
                    used_next      = used_inc;
                    peak_next      = (used_inc > peak_reg) ? used_inc : peak_reg;
                    alloc_cnt_next = alloc_cnt_reg + 1'b1;
                end
                default:
                begin
                    state_next = fbpa_pkg::B_IDLE;
                end
            endcase
        end

        out_valid_next = load || (out_valid_reg && !rsp.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fbpa_pkg::B_IDLE;
            head_reg      <= '0;
            tail_reg      <= AW'(RST_TAIL);
            wrapped_reg   <= 1'b0;
            level_reg     <= CNT_W'(RST_POOL);
            used_reg      <= '0;
            peak_reg      <= '0;
            alloc_cnt_reg <= '0;
            free_cnt_reg  <= '0;
            marks_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            wrapped_reg   <= wrapped_next;
            level_reg     <= level_next;
            used_reg      <= used_next;
            peak_reg      <= peak_next;
            alloc_cnt_reg <= alloc_cnt_next;
            free_cnt_reg  <= free_cnt_next;
            marks_reg     <= marks_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_status_reg <= st_new;
            out_grant_reg  <= grant_new;
            out_free_reg   <= level_next;
            out_used_reg   <= used_next;
            out_peak_reg   <= peak_next;
            out_alloc_reg  <= alloc_cnt_next;
            out_freed_reg  <= free_cnt_next;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.granted_index = out_grant_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.free_blocks   = out_free_reg;
    assign rsp.in_use        = out_used_reg;
    assign rsp.peak_in_use   = out_peak_reg;
    assign rsp.alloc_total   = out_alloc_reg;
    assign rsp.free_total    = out_freed_reg;

endmodule

/* rtl/core/fbpa_checker.sv */
// Port-level assertions for the fixed block pool allocator, bound to the top level.
module fbpa_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic [fbpa_pkg::IDX_W-1:0]  rsp_granted_index,
    input logic [fbpa_pkg::STAT_W-1:0] rsp_status,
    input logic [fbpa_pkg::CNT_W-1:0]  rsp_free_blocks,
    input logic [fbpa_pkg::CNT_W-1:0]  rsp_in_use,
    input logic [fbpa_pkg::CNT_W-1:0]  rsp_peak_in_use
);

    // a rejected request never hands out an index
    a_reject_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != fbpa_pkg::ST_OK) |-> rsp_granted_index == '0)
        else $error("rejected transaction carries a granted index");

    // pool-empty is only reported with nothing on the free list
    a_empty_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == fbpa_pkg::ST_EMPTY) |-> rsp_free_blocks == '0)
        else $error("pool empty reported with free blocks left");

    a_peak_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_in_use <= rsp_peak_in_use)
        else $error("in-use count above its peak");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_granted_index) && $stable(rsp_in_use))
        else $error("stalled response changed");

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_granted_index (rsp.granted_index),
    .rsp_status        (rsp.status),
    .rsp_free_blocks   (rsp.free_blocks),
    .rsp_in_use        (rsp.in_use),
    .rsp_peak_in_use   (rsp.peak_in_use)
);

/* dv/tb_fixed_block_pool_allocator.sv */
// Self-checking testbench for the fixed block pool allocator: directed table, then random phases.
module tb_fixed_block_pool_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDX_W       = fbpa_pkg::IDX_W;
    localparam int CNT_W       = fbpa_pkg::CNT_W;
    localparam int TOT_W       = fbpa_pkg::TOT_W;
    localparam int DEPTH       = 64;
    localparam int GROW_BIAS   = 85;   // alloc share while filling the pool
    localparam int SHRINK_BIAS = 15;   // alloc share while draining it
    localparam int RANDOM_SIZE = -1;   // phase picks a pool size of its own
    localparam int SHOW_LIMIT  = 10;

    // Short local names for the request and status codes.
    localparam logic              FN_ALLOC = fbpa_pkg::FUNC_ALLOC;
    localparam logic              FN_FREE  = fbpa_pkg::FUNC_FREE;
    localparam fbpa_pkg::status_t S_OK     = fbpa_pkg::ST_OK;
    localparam fbpa_pkg::status_t S_EMPTY  = fbpa_pkg::ST_EMPTY;
    localparam fbpa_pkg::status_t S_BAD    = fbpa_pkg::ST_BAD_FREE;

    // One response transaction as the checker sees it.
    typedef struct packed {
        logic [IDX_W-1:0]  granted;
        fbpa_pkg::status_t status;
        logic [CNT_W-1:0]  free_blocks;
        logic [CNT_W-1:0]  in_use;
        logic [CNT_W-1:0]  peak;
        logic [TOT_W-1:0]  alloc_total;
        logic [TOT_W-1:0]  free_total;
    } outcome_t;

    typedef enum logic { ROW_REQ, ROW_CFG } row_kind_t;

    // Directed row: a request (arg is the block index) or a pool size write (arg is the size).
    // Where typed is set, want holds the outcome read straight off the spec.
    typedef struct {
        row_kind_t        kind;
        logic             func;
        logic [CNT_W-1:0] arg;
        bit               typed;
        outcome_t         want;
    } row_t;

    typedef struct {
        int size;
        int items;
        int gap_pct;
        int stall_pct;
        int hold;
    } phase_t;

    localparam int DIR_ROWS = 23;

    // Pool starts at 64 blocks after reset.
    row_t directed_rows [DIR_ROWS] = '{
        '{ROW_REQ, FN_ALLOC, 7'd0,   1'b1, '{6'd0, S_OK,    7'd63, 7'd1, 7'd1, 32'd1, 32'd0}},
        '{ROW_REQ, FN_ALLOC, 7'd0,   1'b1, '{6'd1, S_OK,    7'd62, 7'd2, 7'd2, 32'd2, 32'd0}},
        '{ROW_REQ, FN_FREE,  7'd0,   1'b1, '{6'd0, S_OK,    7'd63, 7'd1, 7'd2, 32'd2, 32'd1}},
        // double free
        '{ROW_REQ, FN_FREE,  7'd0,   1'b1, '{6'd0, S_BAD,   7'd63, 7'd1, 7'd2, 32'd2, 32'd1}},
        // never handed out
        '{ROW_REQ, FN_FREE,  7'd63,  1'b1, '{6'd0, S_BAD,   7'd63, 7'd1, 7'd2, 32'd2, 32'd1}},
        // index field is don't-care on allocate
        '{ROW_REQ, FN_ALLOC, 7'd63,  1'b1, '{6'd2, S_OK,    7'd62, 7'd2, 7'd2, 32'd3, 32'd1}},
        '{ROW_REQ, FN_FREE,  7'd1,   1'b1, '{6'd0, S_OK,    7'd63, 7'd1, 7'd2, 32'd3, 32'd2}},
        '{ROW_REQ, FN_FREE,  7'd2,   1'b1, '{6'd0, S_OK,    7'd64, 7'd0, 7'd2, 32'd3, 32'd3}},
        '{ROW_REQ, FN_ALLOC, 7'd0,   1'b0, '0},
        // zero-sized pool: nothing can be granted or returned
        '{ROW_CFG, FN_ALLOC, 7'd0,   1'b0, '0},
        '{ROW_REQ, FN_ALLOC, 7'd0,   1'b1, '{6'd0, S_EMPTY, 7'd0,  7'd0, 7'd0, 32'd0, 32'd0}},
        '{ROW_REQ, FN_FREE,  7'd0,   1'b1, '{6'd0, S_BAD,   7'd0,  7'd0, 7'd0, 32'd0, 32'd0}},
        // oversized pool clamps to the depth
        '{ROW_CFG, FN_ALLOC, 7'd127, 1'b0, '0},
        '{ROW_REQ, FN_ALLOC, 7'd42,  1'b1, '{6'd0, S_OK,    7'd63, 7'd1, 7'd1, 32'd1, 32'd0}},
        '{ROW_REQ, FN_FREE,  7'd62,  1'b1, '{6'd0, S_BAD,   7'd63, 7'd1, 7'd1, 32'd1, 32'd0}},
        '{ROW_REQ, FN_FREE,  7'd0,   1'b1, '{6'd0, S_OK,    7'd64, 7'd0, 7'd1, 32'd1, 32'd1}},
        // single block: empty pool and out-of-range free
        '{ROW_CFG, FN_ALLOC, 7'd1,   1'b0, '0},
        '{ROW_REQ, FN_ALLOC, 7'd0,   1'b1, '{6'd0, S_OK,    7'd0,  7'd1, 7'd1, 32'd1, 32'd0}},
        '{ROW_REQ, FN_ALLOC, 7'd0,   1'b1, '{6'd0, S_EMPTY, 7'd0,  7'd1, 7'd1, 32'd1, 32'd0}},
        '{ROW_REQ, FN_FREE,  7'd1,   1'b1, '{6'd0, S_BAD,   7'd0,  7'd1, 7'd1, 32'd1, 32'd0}},
        '{ROW_REQ, FN_FREE,  7'd0,   1'b1, '{6'd0, S_OK,    7'd1,  7'd0, 7'd1, 32'd1, 32'd1}},
        '{ROW_REQ, FN_ALLOC, 7'd0,   1'b0, '0},
        '{ROW_CFG, FN_ALLOC, 7'd64,  1'b0, '0}
    };

    // Random phases: pool size, request count, sender gap %, receiver stall %, long hold-off.
    phase_t plan [8] = '{
        '{64,          200, 0,  0,  50},
        '{127,         200, 79, 0,  0},
        '{0,           30,  0,  79, 0},
        '{RANDOM_SIZE, 200, 28, 28, 0},
        '{1,           80,  0,  0,  60},
        '{64,          250, 0,  79, 0},
        '{RANDOM_SIZE, 200, 79, 0,  0},
        '{64,          150, 28, 28, 80}
    };

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CNT_W-1:0] cfg_wdata;

    fbpa_req_if req_ch ();
    fbpa_rsp_if rsp_ch ();

    fixed_block_pool_allocator #(
        .POOL_DEPTH (DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // ---------------------------------------------------------------------------------------
    // Pool predictor: FIFO free list of indices, allocation marks and running statistics.
    // ---------------------------------------------------------------------------------------
    logic [IDX_W-1:0] free_list [DEPTH];
    logic             taken     [DEPTH];
    logic [IDX_W-1:0] take_pos;
    logic [IDX_W-1:0] list_tail;
    logic [CNT_W-1:0] list_level;
    logic [CNT_W-1:0] pool_limit;     // configured size clamped to the depth
    logic [CNT_W-1:0] blocks_used;
    logic [CNT_W-1:0] blocks_peak;
    logic [TOT_W-1:0] grants_made;
    logic [TOT_W-1:0] returns_made;

    outcome_t awaited_outcomes [$];

    // Stimulus knobs; the gap and stall shares change only between phases.
    int gap_pct;
    int stall_pct;
    int hold_request;
    bit filling;

    // Bookkeeping.
    int fault_count;
    int shown_count;
    int requests_sent;
    int settings_used;
    int grants_seen;
    int empties_seen;
    int rejects_seen;

    function automatic void pool_reinit(logic [CNT_W-1:0] size);
        pool_limit = (size > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : size;
        for (int i = 0; i < DEPTH; i++)
        begin
            free_list[i] = IDX_W'(i);
            taken[i]     = 1'b0;
        end
        take_pos     = '0;
        list_tail    = pool_limit[IDX_W-1:0];   // a full pool wraps the tail to 0
        list_level   = pool_limit;
        blocks_used  = '0;
        blocks_peak  = '0;
        grants_made  = '0;
        returns_made = '0;
    endfunction

    // Applies one request to the predicted pool and returns the response it should give.
    function automatic outcome_t pool_outcome(logic func, logic [IDX_W-1:0] idx);
        outcome_t r;
        r        = '0;
        r.status = S_OK;
        if (func == FN_ALLOC)
        begin
            if (list_level == 0)
                r.status = S_EMPTY;
            else
            begin
                r.granted          = free_list[take_pos];
                taken[r.granted]   = 1'b1;
                take_pos           = take_pos + 1'b1;
                list_level         = list_level - 1'b1;
                blocks_used        = blocks_used + 1'b1;
                if (blocks_used > blocks_peak)
                    blocks_peak = blocks_used;
                grants_made        = grants_made + 1'b1;
            end
        end
        else
        begin
            if ({1'b0, idx} >= pool_limit || !taken[idx])
                r.status = S_BAD;
            else
            begin
                taken[idx]           = 1'b0;
                free_list[list_tail] = idx;
                list_tail            = list_tail + 1'b1;
                list_level           = list_level + 1'b1;
                if (blocks_used > 0)
                    blocks_used = blocks_used - 1'b1;
                returns_made         = returns_made + 1'b1;
            end
        end
        r.free_blocks = list_level;
        r.in_use      = blocks_used;
        r.peak        = blocks_peak;
        r.alloc_total = grants_made;
        r.free_total  = returns_made;
        return r;
    endfunction

    // Random request shaped by the predicted pool: mostly well-formed alloc/free traffic that
    // swings between filling and draining, plus some noise (stray frees, blind allocates).
    function automatic void choose_request(output logic func, output logic [IDX_W-1:0] idx);
        int pick;
        int bias;
        pick = 0;
        idx  = IDX_W'($urandom_range(0, DEPTH - 1));
        if (filling && list_level == 0 && $urandom_range(0, 3) == 0)
            filling = 1'b0;
        else if (!filling && blocks_used == 0 && $urandom_range(0, 3) == 0)
            filling = 1'b1;
        else if ($urandom_range(0, 99) == 0)
            filling = !filling;
        bias = filling ? GROW_BIAS : SHRINK_BIAS;
        if ($urandom_range(0, 99) < 12)
            func = $urandom_range(0, 1) ? FN_FREE : FN_ALLOC;
        else if (blocks_used == 0 || $urandom_range(0, 99) < bias)
            func = FN_ALLOC;
        else
        begin
            // free the k-th block currently handed out
            func = FN_FREE;
            pick = $urandom_range(0, blocks_used - 1);
            for (int i = 0; i < DEPTH; i++)
            begin
                if (taken[i])
                begin
                    if (pick == 0)
                        idx = IDX_W'(i);
                    pick--;
                end
            end
        end
    endfunction

    // ---------------------------------------------------------------------------------------
    // Clock, reset and the limit on the whole run.
    // ---------------------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("timeout: %0d responses still awaited", awaited_outcomes.size());
        $display("[fixed_block_pool_allocator] ERROR");
        $finish;
    end

    // ---------------------------------------------------------------------------------------
    // Response side: ready toggles at the falling edge, with an optional long hold-off so the
    // command queue fills and the request side backs up.
    // ---------------------------------------------------------------------------------------
    initial
    begin
        int hold_left;
        hold_left    = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready = 1'b0;
            end
            else
                rsp_ch.ready = ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Compare each response transaction with the oldest awaited outcome, field by field.
    function automatic void check_response();
        outcome_t got;
        outcome_t want;
        bit       bad;
        got.granted     = rsp_ch.granted_index;
        got.status      = fbpa_pkg::status_t'(rsp_ch.status);
        got.free_blocks = rsp_ch.free_blocks;
        got.in_use      = rsp_ch.in_use;
        got.peak        = rsp_ch.peak_in_use;
        got.alloc_total = rsp_ch.alloc_total;
        got.free_total  = rsp_ch.free_total;
        case (got.status)
            S_EMPTY: empties_seen += 1;
            S_BAD:   rejects_seen += 1;
            default: ;
        endcase
        if (awaited_outcomes.size() == 0)
        begin
            fault_count++;
            if (shown_count < SHOW_LIMIT)
                $display("%0t: response with none awaited: idx=%0d st=%0d", $realtime,
                         got.granted, got.status);
            shown_count++;
            return;
        end
        want = awaited_outcomes.pop_front();
        bad = (got.granted     !== want.granted)     ||
              (got.status      !== want.status)      ||
              (got.free_blocks !== want.free_blocks) ||
              (got.in_use      !== want.in_use)      ||
              (got.peak        !== want.peak)        ||
              (got.alloc_total !== want.alloc_total) ||
              (got.free_total  !== want.free_total);
        if (bad)
        begin
            fault_count++;
            if (shown_count < SHOW_LIMIT)
            begin
                $display("%0t: mismatch exp idx=%0d st=%0d free=%0d used=%0d peak=%0d a=%0d f=%0d",
                         $realtime, want.granted, want.status, want.free_blocks, want.in_use,
                         want.peak, want.alloc_total, want.free_total);
                $display("%0t:          got idx=%0d st=%0d free=%0d used=%0d peak=%0d a=%0d f=%0d",
                         $realtime, got.granted, got.status, got.free_blocks, got.in_use,
                         got.peak, got.alloc_total, got.free_total);
            end
            shown_count++;
        end
    endfunction

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
                check_response();
        end
    end

    // ---------------------------------------------------------------------------------------
    // Request side. Every task is entered and left at a falling edge; after the last request
    // valid is left high, so the caller either offers the next one or drops valid at once.
    // ---------------------------------------------------------------------------------------
    task automatic offer_request(logic func, logic [IDX_W-1:0] idx, bit typed, outcome_t want);
        outcome_t predicted;
        while ($urandom_range(0, 99) < gap_pct)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid       = 1'b1;
        req_ch.func        = func;
        req_ch.block_index = idx;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        // accepted: predictor always advances, typed rows override the expectation
        predicted = pool_outcome(func, idx);
        if (predicted.status == S_OK && func == FN_ALLOC)
            grants_seen++;
        awaited_outcomes.push_back(typed ? want : predicted);
        requests_sent++;
        @(negedge clk);
    endtask

    // Drop valid, wait for every awaited response, then let the pipeline settle before
    // anything touches the configuration.
    task automatic wait_idle();
        req_ch.valid = 1'b0;
        while (awaited_outcomes.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Pool size write; the block re-initialises in the cycle after the write edge.
    task automatic write_pool_size(logic [CNT_W-1:0] size);
        cfg_we    = 1'b1;
        cfg_wdata = size;
        @(negedge clk);
        cfg_we    = 1'b0;
        pool_reinit(size);
        settings_used++;
        repeat (2) @(negedge clk);
    endtask

    // ---------------------------------------------------------------------------------------
    // Main sequence.
    // ---------------------------------------------------------------------------------------
    initial
    begin
        logic             func;
        logic [IDX_W-1:0] idx;
        logic [CNT_W-1:0] size;

        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        req_ch.valid       = 1'b0;
        req_ch.func        = FN_ALLOC;
        req_ch.block_index = '0;
        gap_pct            = 0;
        stall_pct          = 0;
        hold_request       = 0;
        filling            = 1'b1;
        fault_count        = 0;
        shown_count        = 0;
        requests_sent      = 0;
        settings_used      = 0;
        grants_seen        = 0;
        empties_seen       = 0;
        rejects_seen       = 0;
        pool_reinit(CNT_W'(fbpa_pkg::BLOCK_COUNT_RESET));

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table, no idling on either side.
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
            begin
                wait_idle();
                write_pool_size(directed_rows[i].arg);
            end
            else
                offer_request(directed_rows[i].func, directed_rows[i].arg[IDX_W-1:0],
                              directed_rows[i].typed, directed_rows[i].want);
        end

        // Random phases, each under its own pool size and idling pattern.
        foreach (plan[p])
        begin
            wait_idle();
            gap_pct   = plan[p].gap_pct;
            stall_pct = plan[p].stall_pct;
            if (plan[p].size == RANDOM_SIZE)
                size = CNT_W'($urandom_range(2, DEPTH - 1));
            else
                size = CNT_W'(plan[p].size);
            write_pool_size(size);
            filling = 1'b1;
            if (plan[p].hold > 0)
                hold_request = plan[p].hold;
            repeat (plan[p].items)
            begin
                choose_request(func, idx);
                offer_request(func, idx, 1'b0, '0);
            end
        end

        wait_idle();
        repeat (8) @(posedge clk);

        $display("covered %0d requests over %0d pool size settings", requests_sent,
                 settings_used);
        $display("grants %0d, empty-pool refusals %0d, rejected frees %0d, faults %0d",
                 grants_seen, empties_seen, rejects_seen, fault_count);
        if (fault_count == 0 && awaited_outcomes.size() == 0)
            $display("[fixed_block_pool_allocator] OK");
        else
            $display("[fixed_block_pool_allocator] ERROR");
        $finish;
    end

endmodule
